// ===== rtl/core/assert_macros.svh =====
// Assertion macros for the checker file of this block.
// Both macros sample on clk and are quiet while rst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that a property holds at every rising clock edge.
`define RDSU_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Check that an expression is never true.
`define RDSU_NEVER(lbl, expr, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);

`endif

// ===== rtl/core/rdsu_pkg.sv =====
// Shared types, codes and helper functions of the UECP frame decoder.
// No dependencies; used by the top level, its checker and the testbench.
`default_nettype none

package rdsu_pkg;

    localparam int FRAME_BYTES_DEF = 256;
    localparam int TEXT_BYTES_DEF  = 256;
    localparam int PS_CHARS        = 8;
    localparam int POS_W           = 11;

    localparam logic [7:0]  START_BYTE = 8'hFE;
    localparam logic [7:0]  STOP_BYTE  = 8'hFF;
    localparam logic [7:0]  ESC_BYTE   = 8'hFD;
    localparam logic [15:0] CRC_INIT   = 16'hFFFF;

    // Message element codes
    localparam logic [7:0] MEC_PS    = 8'd2;
    localparam logic [7:0] MEC_SHORT = 8'd3;
    localparam logic [7:0] MEC_RT    = 8'd10;
    localparam logic [7:0] MEC_VAR   = 8'h30;

    typedef enum logic [1:0] {
        CMD_BYTE    = 2'd0,
        CMD_READ_PS = 2'd1,
        CMD_READ_RT = 2'd2,
        CMD_CHANNEL = 2'd3
    } cmd_t;

    typedef struct packed {
        logic [1:0] cmd;
        logic [7:0] data_byte;
        logic [7:0] char_index;
        logic [7:0] channel;
    } req_t;

    typedef struct packed {
        logic [7:0] read_char;
        logic       frame_done;
        logic       crc_good;
        logic       ps_updated;
        logic       rt_updated;
        logic       frame_overflow;
    } res_t;

    // One byte of CRC-16-CCITT, byte-wise form
    function automatic logic [15:0] crc16_step(input logic [15:0] c_in, input logic [7:0] b);
        logic [15:0] c;
        c = {c_in[7:0], c_in[15:8]};
        c = c ^ {8'h00, b};
        c = c ^ {12'h000, c[7:4]};
        c = c ^ {c[3:0], 12'h000};
        c = c ^ {3'b000, c[7:0], 5'b00000};
        return c;
    endfunction

    // Undo a stuffed pair: second byte 0, 1 or 2
    function automatic logic [7:0] unstuff(input logic [1:0] code);
        logic [7:0] v;
        case (code)
            2'd0:    v = ESC_BYTE;
            2'd1:    v = START_BYTE;
            default: v = STOP_BYTE;
        endcase
        return v;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/core/rdsu_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none

module rdsu_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256,
    localparam int AW = $clog2(DEPTH)
) (
    input  wire logic             clk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic [AW-1:0]    raddr,
    output logic      [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write, and read through a registered output
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

// ===== rtl/core/rds_uecp_frame_decoder.sv =====
// UECP frame decoder top level: frame collection, CRC check and element walk.
// Depends on rdsu_pkg and rdsu_ram.
`default_nettype none

// One request in gives one result out; a stream byte, a read or a channel select
// passes through its states to S_DONE, plus any wait on the result side.
// The stop byte starts the frame pass through the single read port of the frame
// RAM: a read and a CRC update per frame byte, then the checksum and length
// fetch, then the element header bytes and each copied PS or text character in
// turn. The block takes no new request until that result is handed over.
// No clearing pass is needed after reset.
module rds_uecp_frame_decoder #(
    parameter int FRAME_BYTES = rdsu_pkg::FRAME_BYTES_DEF,
    parameter int TEXT_BYTES  = rdsu_pkg::TEXT_BYTES_DEF
) (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           req_valid,
    output logic                req_stall,
    input  wire rdsu_pkg::req_t req,
    output logic                res_valid,
    input  wire logic           res_stall,
    output rdsu_pkg::res_t      res
);

    import rdsu_pkg::*;

    localparam int FA_W  = $clog2(FRAME_BYTES);
    localparam int LEN_W = $clog2(FRAME_BYTES + 1);
    localparam int CNT_W = (LEN_W > 9) ? LEN_W : 9;
    localparam int RT_AW = $clog2(TEXT_BYTES);

    typedef enum logic [18:0] {
        S_IDLE    = 19'b0000000000000000001,
        S_BYTE    = 19'b0000000000000000010,
        S_RT_OUT  = 19'b0000000000000000100,
        S_FIN     = 19'b0000000000000001000,
        S_CRC_RD  = 19'b0000000000000010000,
        S_CRC_UPD = 19'b0000000000000100000,
        S_CHK_HI  = 19'b0000000000001000000,
        S_CHK_LO  = 19'b0000000000010000000,
        S_LEN     = 19'b0000000000100000000,
        S_WALK    = 19'b0000000001000000000,
        S_MEC     = 19'b0000000010000000000,
        S_SKIP    = 19'b0000000100000000000,
        S_MEL     = 19'b0000001000000000000,
        S_RT_RD   = 19'b0000010000000000000,
        S_RT_WR   = 19'b0000100000000000000,
        S_PS_RD   = 19'b0001000000000000000,
        S_PS_WR   = 19'b0010000000000000000,
        S_DONE    = 19'b0100000000000000000,
        S_SPARE   = 19'b1000000000000000000
    } state_t;

    state_t                 state_reg, state_next;
    logic [LEN_W-1:0]       len_reg, len_next;
    logic                   in_frame_reg, in_frame_next;
    logic                   esc_reg, esc_next;
    logic [7:0]             byte_reg, byte_next;
    logic [7:0]             ps_reg [PS_CHARS];
    logic [7:0]             ps_next [PS_CHARS];
    logic [TEXT_BYTES-1:0]  rt_valid_reg, rt_valid_next;
    logic [7:0]             last_chan_reg, last_chan_next;
    logic                   chan_known_reg, chan_known_next;
    logic                   res_valid_reg, res_valid_next;
    res_t                   res_reg, res_next;

    logic [15:0]            crc_reg, crc_next;
    logic [CNT_W-1:0]       cnt_reg, cnt_next;
    logic [7:0]             hi_reg, hi_next;
    logic signed [9:0]      left_reg, left_next;
    logic [POS_W-1:0]       pos_reg, pos_next;
    logic [POS_W-1:0]       step_reg, step_next;
    logic [8:0]             lim_reg, lim_next;
    logic                   zero_reg, zero_next;
    logic [7:0]             idx_reg, idx_next;
    res_t                   work_reg, work_next;

    logic                   accept;
    logic                   put_req;
    logic [7:0]             put_val;
    logic                   put_full;
    logic                   msg_rd;
    logic [POS_W-1:0]       msg_k;
    logic [7:0]             msg_data;
    logic                   adv_en;
    logic [POS_W-1:0]       adv_step;
    logic [8:0]             mel_m1;

    logic                   f_we;
    logic [FA_W-1:0]        f_waddr;
    logic [7:0]             f_wdata;
    logic [FA_W-1:0]        f_raddr;
    logic [7:0]             f_rdata;
    logic                   r_we;
    logic [RT_AW-1:0]       r_waddr;
    logic [7:0]             r_wdata;
    logic [RT_AW-1:0]       r_raddr;
    logic [7:0]             r_rdata;

    rdsu_ram #(
        .WIDTH (8),
        .DEPTH (FRAME_BYTES)
    ) u_frame_ram (
        .clk   (clk),
        .we    (f_we),
        .waddr (f_waddr),
        .wdata (f_wdata),
        .raddr (f_raddr),
        .rdata (f_rdata)
    );

    rdsu_ram #(
        .WIDTH (8),
        .DEPTH (TEXT_BYTES)
    ) u_text_ram (
        .clk   (clk),
        .we    (r_we),
        .waddr (r_waddr),
        .wdata (r_wdata),
        .raddr (r_raddr),
        .rdata (r_rdata)
    );

    // Handshake
    assign req_stall = (state_reg != S_IDLE) || (res_valid_reg && res_stall);
    assign accept    = req_valid && !req_stall;
    assign res_valid = res_valid_reg;
    assign res       = res_reg;

    assign put_full = (len_reg >= LEN_W'(FRAME_BYTES));
    assign msg_data = zero_reg ? 8'h00 : f_rdata;
    assign mel_m1   = {1'b0, msg_data} - 9'd1;

    // Sequencer
    always_comb
    begin
        state_next      = state_reg;
        len_next        = len_reg;
        in_frame_next   = in_frame_reg;
        esc_next        = esc_reg;
        byte_next       = byte_reg;
        ps_next         = ps_reg;
        rt_valid_next   = rt_valid_reg;
        last_chan_next  = last_chan_reg;
        chan_known_next = chan_known_reg;
        res_valid_next  = res_valid_reg && res_stall;
        res_next        = res_reg;
        crc_next        = crc_reg;
        cnt_next        = cnt_reg;
        hi_next         = hi_reg;
        left_next       = left_reg;
        pos_next        = pos_reg;
        step_next       = step_reg;
        lim_next        = lim_reg;
        idx_next        = idx_reg;
        work_next       = work_reg;
        put_req         = 1'b0;
        put_val         = 8'h00;
        msg_rd          = 1'b0;
        msg_k           = '0;
        adv_en          = 1'b0;
        adv_step        = '0;
        f_we            = 1'b0;
        f_waddr         = len_reg[FA_W-1:0];
        f_wdata         = put_val;
        f_raddr         = '0;
        r_we            = 1'b0;
        r_waddr         = cnt_reg[RT_AW-1:0];
        r_wdata         = msg_data;
        r_raddr         = req.char_index[RT_AW-1:0];

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    work_next = '0;
                    byte_next = req.data_byte;
                    case (req.cmd)
                        CMD_BYTE:
                        begin
                            if (!in_frame_reg)
                            begin
                                if (req.data_byte == START_BYTE)
                                begin
                                    in_frame_next = 1'b1;
                                    len_next      = '0;
                                    esc_next      = 1'b0;
                                end
                                state_next = S_DONE;
                            end
                            else if (esc_reg)
                            begin
                                esc_next = 1'b0;
                                put_req  = 1'b1;
                                if (req.data_byte < 8'd3)
                                begin
                                    put_val    = unstuff(req.data_byte[1:0]);
                                    state_next = S_DONE;
                                end
                                else
                                begin
                                    put_val    = ESC_BYTE;
                                    state_next = put_full ? S_DONE : S_BYTE;
                                end
                            end
                            else
                            begin
                                state_next = S_BYTE;
                            end
                        end
                        CMD_READ_PS:
                        begin
                            if (req.char_index < 8'(PS_CHARS))
                            begin
                                work_next.read_char = ps_reg[req.char_index[2:0]];
                            end
                            state_next = S_DONE;
                        end
                        CMD_READ_RT:
                        begin
                            idx_next   = req.char_index;
                            state_next = S_RT_OUT;
                        end
                        default:
                        begin
                            if (!chan_known_reg || (req.channel != last_chan_reg))
                            begin
                                for (int i = 0; i < PS_CHARS; i++)
                                begin
                                    ps_next[i] = 8'h00;
                                end
                                rt_valid_next   = '0;
                                last_chan_next  = req.channel;
                                chan_known_next = 1'b1;
                            end
                            state_next = S_DONE;
                        end
                    endcase
                end
            end
            // Handle a byte that is not the second byte of a stuffed pair
            S_BYTE:
            begin
                if (byte_reg == STOP_BYTE)
                begin
                    in_frame_next = 1'b0;
                    state_next    = S_FIN;
                end
                else if (byte_reg == ESC_BYTE)
                begin
                    esc_next   = 1'b1;
                    state_next = S_DONE;
                end
                else
                begin
                    put_req    = 1'b1;
                    put_val    = byte_reg;
                    state_next = S_DONE;
                end
            end
            S_RT_OUT:
            begin
                if (({1'b0, idx_reg} < 9'(TEXT_BYTES)) && rt_valid_reg[idx_reg[RT_AW-1:0]])
                begin
                    work_next.read_char = r_rdata;
                end
                state_next = S_DONE;
            end
            S_FIN:
            begin
                work_next.frame_done = 1'b1;
                crc_next = CRC_INIT;
                cnt_next = '0;
                state_next = (len_reg < LEN_W'(6)) ? S_DONE : S_CRC_RD;
            end
            // CRC over all bytes ahead of the checksum
            S_CRC_RD:
            begin
                if (cnt_reg == CNT_W'(len_reg - LEN_W'(2)))
                begin
                    f_raddr    = FA_W'(len_reg - LEN_W'(2));
                    state_next = S_CHK_HI;
                end
                else
                begin
                    f_raddr    = cnt_reg[FA_W-1:0];
                    state_next = S_CRC_UPD;
                end
            end
            S_CRC_UPD:
            begin
                crc_next   = crc16_step(crc_reg, f_rdata);
                cnt_next   = cnt_reg + CNT_W'(1);
                state_next = S_CRC_RD;
            end
            S_CHK_HI:
            begin
                hi_next    = f_rdata;
                f_raddr    = FA_W'(len_reg - LEN_W'(1));
                state_next = S_CHK_LO;
            end
            S_CHK_LO:
            begin
                if ((crc_reg ^ CRC_INIT) == {hi_reg, f_rdata})
                begin
                    work_next.crc_good = 1'b1;
                    f_raddr    = FA_W'(3);
                    state_next = S_LEN;
                end
                else
                begin
                    state_next = S_DONE;
                end
            end
            S_LEN:
            begin
                left_next  = $signed({2'b00, f_rdata});
                pos_next   = '0;
                state_next = S_WALK;
            end
            // Walk the message elements
            S_WALK:
            begin
                if (left_reg[9] || (left_reg == 10'sd0))
                begin
                    state_next = S_DONE;
                end
                else
                begin
                    msg_rd     = 1'b1;
                    msg_k      = pos_reg;
                    state_next = S_MEC;
                end
            end
            S_MEC:
            begin
                cnt_next = '0;
                case (msg_data)
                    MEC_RT:
                    begin
                        msg_rd     = 1'b1;
                        msg_k      = pos_reg + POS_W'(3);
                        state_next = S_MEL;
                    end
                    MEC_PS:
                    begin
                        state_next = S_PS_RD;
                    end
                    MEC_SHORT:
                    begin
                        adv_en     = 1'b1;
                        adv_step   = POS_W'(4);
                        state_next = S_WALK;
                    end
                    MEC_VAR:
                    begin
                        msg_rd     = 1'b1;
                        msg_k      = pos_reg + POS_W'(1);
                        state_next = S_SKIP;
                    end
                    default:
                    begin
                        state_next = S_DONE;
                    end
                endcase
            end
            S_SKIP:
            begin
                adv_en     = 1'b1;
                adv_step   = POS_W'(msg_data) + POS_W'(2);
                state_next = S_WALK;
            end
            // Radiotext: drop old text, then copy
            S_MEL:
            begin
                if (msg_data == 8'h00)
                begin
                    lim_next = '0;
                end
                else if (mel_m1 > 9'(TEXT_BYTES))
                begin
                    lim_next = 9'(TEXT_BYTES);
                end
                else
                begin
                    lim_next = mel_m1;
                end
                rt_valid_next        = '0;
                work_next.rt_updated = 1'b1;
                step_next            = POS_W'(msg_data) + POS_W'(4);
                state_next           = S_RT_RD;
            end
            S_RT_RD:
            begin
                if (cnt_reg == CNT_W'(lim_reg))
                begin
                    adv_en     = 1'b1;
                    adv_step   = step_reg;
                    state_next = S_WALK;
                end
                else
                begin
                    msg_rd     = 1'b1;
                    msg_k      = pos_reg + POS_W'(5) + POS_W'(cnt_reg);
                    state_next = S_RT_WR;
                end
            end
            S_RT_WR:
            begin
                r_we       = 1'b1;
                rt_valid_next[cnt_reg[RT_AW-1:0]] = 1'b1;
                cnt_next   = cnt_reg + CNT_W'(1);
                state_next = S_RT_RD;
            end
            // Program service: eight characters
            S_PS_RD:
            begin
                if (cnt_reg == CNT_W'(PS_CHARS))
                begin
                    work_next.ps_updated = 1'b1;
                    adv_en     = 1'b1;
                    adv_step   = POS_W'(11);
                    state_next = S_WALK;
                end
                else
                begin
                    msg_rd     = 1'b1;
                    msg_k      = pos_reg + POS_W'(3) + POS_W'(cnt_reg);
                    state_next = S_PS_WR;
                end
            end
            S_PS_WR:
            begin
                ps_next[cnt_reg[2:0]] = msg_data;
                cnt_next   = cnt_reg + CNT_W'(1);
                state_next = S_PS_RD;
            end
            S_DONE:
            begin
                if (!res_valid_reg || !res_stall)
                begin
                    res_next       = work_reg;
                    res_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        // Append one byte to the frame, or drop the frame when full
        if (put_req)
        begin
            if (put_full)
            begin
                in_frame_next            = 1'b0;
                esc_next                 = 1'b0;
                work_next.frame_overflow = 1'b1;
            end
            else
            begin
                f_we     = 1'b1;
                f_wdata  = put_val;
                len_next = len_reg + LEN_W'(1);
            end
        end

        // Fetch a message byte
        if (msg_rd)
        begin
            f_raddr = FA_W'(msg_k + POS_W'(4));
        end

        // Advance to the next element
        if (adv_en)
        begin
            pos_next  = pos_reg + adv_step;
            left_next = left_reg - $signed(10'(adv_step));
        end
    end

    // From the checksum on, a message byte reads as zero
    assign zero_next = (({1'b0, msg_k} + 12'd6) >= 12'(len_reg));

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            len_reg        <= '0;
            in_frame_reg   <= 1'b0;
            esc_reg        <= 1'b0;
            rt_valid_reg   <= '0;
            last_chan_reg  <= 8'h00;
            chan_known_reg <= 1'b0;
            res_valid_reg  <= 1'b0;
            for (int i = 0; i < PS_CHARS; i++)
            begin
                ps_reg[i] <= 8'h00;
            end
        end
        else
        begin
            state_reg      <= state_next;
            len_reg        <= len_next;
            in_frame_reg   <= in_frame_next;
            esc_reg        <= esc_next;
            rt_valid_reg   <= rt_valid_next;
            last_chan_reg  <= last_chan_next;
            chan_known_reg <= chan_known_next;
            res_valid_reg  <= res_valid_next;
            ps_reg         <= ps_next;
        end
    end

    // Working registers
    always_ff @(posedge clk)
    begin
        byte_reg <= byte_next;
        res_reg  <= res_next;
        crc_reg  <= crc_next;
        cnt_reg  <= cnt_next;
        hi_reg   <= hi_next;
        left_reg <= left_next;
        pos_reg  <= pos_next;
        step_reg <= step_next;
        lim_reg  <= lim_next;
        zero_reg <= zero_next;
        idx_reg  <= idx_next;
        work_reg <= work_next;
    end

endmodule

`default_nettype wire

// ===== rtl/core/rdsu_checker.sv =====
// Port-level checks of the UECP frame decoder, bound to the top level.
// Depends on rdsu_pkg and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module rdsu_checker (
    input wire logic           clk,
    input wire logic           rst_n,
    input wire logic           req_valid,
    input wire logic           req_stall,
    input wire logic           res_valid,
    input wire logic           res_stall,
    input wire rdsu_pkg::res_t res
);

    import rdsu_pkg::*;

    // A checked CRC only comes with a finished frame
    `RDSU_ASSERT(a_crc_needs_frame, (res_valid && res.crc_good) |-> res.frame_done, "crc no done")
    // Store updates only follow a good CRC
    `RDSU_NEVER(a_upd_needs_crc, res_valid && !res.crc_good && (res.ps_updated || res.rt_updated), "upd")
    // A dropped frame cannot also finish
    `RDSU_NEVER(a_drop_or_done, res_valid && res.frame_overflow && res.frame_done, "drop and done")
    // A held result blocks new requests
    `RDSU_ASSERT(a_hold_blocks, (res_valid && res_stall) |-> req_stall, "request taken while held")
    // A stalled result stays offered
    `RDSU_ASSERT(a_res_holds, (res_valid && res_stall) |=> res_valid, "result dropped while stalled")

endmodule

bind rds_uecp_frame_decoder rdsu_checker u_rdsu_checker (.*);

`default_nettype wire

// ===== tb/sv/tb_top.sv =====
// Self-checking testbench for the UECP frame decoder: frames, reads, channel selects.
// Depends on rdsu_pkg and the rds_uecp_frame_decoder RTL.
`timescale 1ns / 100ps

module tb_top;
    import rdsu_pkg::*;

    localparam int FB = FRAME_BYTES_DEF;
    localparam int TB = TEXT_BYTES_DEF;
    localparam longint CYCLE_LIMIT = 3000000;

    logic clk;
    logic rst_n;
    logic req_valid;
    logic req_stall;
    req_t req;
    logic res_valid;
    logic res_stall;
    res_t res;

    rds_uecp_frame_decoder i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req       (req),
        .res_valid (res_valid),
        .res_stall (res_stall),
        .res       (res)
    );

    // Decoder state mirror
    logic [7:0] frame_buf [FB];
    int         frame_len;
    bit         collecting;
    bit         esc_seen;
    logic [7:0] ps_chars [PS_CHARS];
    logic [7:0] rt_chars [TB];
    logic [7:0] cur_channel;
    bit         channel_set;

    req_t   pending_reqs[$];
    res_t   expected_res[$];
    int     send_idle_pct;
    int     recv_idle_pct;
    bit     hold_sender;
    bit     req_taken;
    int     error_count;
    longint cycle_count;

    initial clk = 1'b0;
    always #10 clk = ~clk;

    // Message byte of the frame; CRC and beyond read as zero
    function automatic logic [7:0] msg_at(int k);
        if (k >= frame_len - 6)
            return 8'h00;
        return frame_buf[4 + k];
    endfunction

    function automatic bit store_byte(logic [7:0] b);
        if (frame_len >= FB)
            return 1'b0;
        frame_buf[frame_len] = b;
        frame_len++;
        return 1'b1;
    endfunction

    // Close the frame: CRC check, then walk the message elements
    function automatic void close_frame(ref res_t r);
        logic [15:0] c;
        int left;
        int pos;
        int mel;
        int cnt;
        int stride;
        logic [7:0] mec;
        r.frame_done = 1'b1;
        if (frame_len < 6)
            return;
        c = 16'hFFFF;
        for (int i = 0; i < frame_len - 2; i++)
        begin
            c = {c[7:0], c[15:8]};
            c ^= {8'h00, frame_buf[i]};
            c ^= {12'h000, c[7:4]};
            c ^= {c[3:0], 12'h000};
            c ^= {3'b000, c[7:0], 5'b00000};
        end
        c = ~c;
        if (c != {frame_buf[frame_len - 2], frame_buf[frame_len - 1]})
            return;
        r.crc_good = 1'b1;
        left = frame_buf[3];
        pos = 0;
        while (left > 0)
        begin
            mec = msg_at(pos);
            if (mec == MEC_RT)
            begin
                mel = msg_at(pos + 3);
                cnt = (mel != 0) ? mel - 1 : 0;
                if (cnt > TB)
                    cnt = TB;
                foreach (rt_chars[i])
                    rt_chars[i] = 8'h00;
                for (int i = 0; i < cnt; i++)
                    rt_chars[i] = msg_at(pos + 5 + i);
                r.rt_updated = 1'b1;
                stride = mel + 4;
            end
            else if (mec == MEC_PS)
            begin
                for (int i = 0; i < PS_CHARS; i++)
                    ps_chars[i] = msg_at(pos + 3 + i);
                r.ps_updated = 1'b1;
                stride = 11;
            end
            else if (mec == MEC_SHORT)
                stride = 4;
            else if (mec == MEC_VAR)
                stride = int'(msg_at(pos + 1)) + 2;
            else
                break;
            pos += stride;
            left -= stride;
        end
    endfunction

    function automatic void drop_frame(ref res_t r);
        collecting = 1'b0;
        esc_seen = 1'b0;
        r.frame_overflow = 1'b1;
    endfunction

    function automatic void take_stream_byte(logic [7:0] b, ref res_t r);
        if (!collecting)
        begin
            if (b == START_BYTE)
            begin
                collecting = 1'b1;
                frame_len = 0;
                esc_seen = 1'b0;
            end
            return;
        end
        if (esc_seen)
        begin
            esc_seen = 1'b0;
            if (b < 3)
            begin
                if (!store_byte(b == 0 ? ESC_BYTE : (b == 1 ? START_BYTE : STOP_BYTE)))
                    drop_frame(r);
                return;
            end
            if (!store_byte(ESC_BYTE))
            begin
                drop_frame(r);
                return;
            end
        end
        if (b == STOP_BYTE)
        begin
            collecting = 1'b0;
            close_frame(r);
        end
        else if (b == ESC_BYTE)
            esc_seen = 1'b1;
        else if (!store_byte(b))
            drop_frame(r);
    endfunction

    function automatic res_t decode_request(req_t q);
        res_t r;
        r = '0;
        case (cmd_t'(q.cmd))
            CMD_BYTE:    take_stream_byte(q.data_byte, r);
            CMD_READ_PS: if (q.char_index < PS_CHARS) r.read_char = ps_chars[q.char_index];
            CMD_READ_RT: if (q.char_index < TB) r.read_char = rt_chars[q.char_index];
            default:
            begin
                if (!channel_set || q.channel != cur_channel)
                begin
                    foreach (ps_chars[i])
                        ps_chars[i] = 8'h00;
                    foreach (rt_chars[i])
                        rt_chars[i] = 8'h00;
                    cur_channel = q.channel;
                    channel_set = 1'b1;
                end
            end
        endcase
        return r;
    endfunction

    function automatic req_t make_req(cmd_t c, logic [7:0] d, logic [7:0] idx, logic [7:0] ch);
        req_t q;
        q.cmd = c;
        q.data_byte = d;
        q.char_index = idx;
        q.channel = ch;
        return q;
    endfunction

    function automatic void push_byte(logic [7:0] d);
        pending_reqs.push_back(make_req(CMD_BYTE, d, 8'($urandom), 8'($urandom)));
    endfunction

    // Send a body byte, stuffing the three reserved codes
    function automatic void push_stuffed(logic [7:0] d);
        if (d == ESC_BYTE || d == START_BYTE || d == STOP_BYTE)
        begin
            push_byte(ESC_BYTE);
            push_byte(d - ESC_BYTE);
        end
        else
            push_byte(d);
    endfunction

    // Wrap a message in a frame with address, sequence, length and CRC
    function automatic void push_frame(logic [7:0] msg[$], bit bad_crc);
        logic [7:0] body[$];
        logic [15:0] c;
        body.push_back(8'($urandom));
        body.push_back(8'($urandom));
        body.push_back(8'($urandom));
        body.push_back(8'(msg.size()));
        foreach (msg[i])
            body.push_back(msg[i]);
        c = 16'hFFFF;
        foreach (body[i])
        begin
            c = {c[7:0], c[15:8]};
            c ^= {8'h00, body[i]};
            c ^= {12'h000, c[7:4]};
            c ^= {c[3:0], 12'h000};
            c ^= {3'b000, c[7:0], 5'b00000};
        end
        c = ~c;
        if (bad_crc)
            c ^= 16'(1 << $urandom_range(15, 0));
        body.push_back(c[15:8]);
        body.push_back(c[7:0]);
        push_byte(START_BYTE);
        foreach (body[i])
            push_stuffed(body[i]);
        push_byte(STOP_BYTE);
    endfunction

    // Random message of PS, RT, short and variable elements
    function automatic void push_random_frame();
        logic [7:0] msg[$];
        int n;
        int len;
        n = $urandom_range(3, 1);
        for (int e = 0; e < n; e++)
        begin
            case ($urandom_range(4, 0))
                0, 1:
                begin
                    msg.push_back(MEC_PS);
                    msg.push_back(8'($urandom));
                    msg.push_back(8'($urandom));
                    for (int i = 0; i < PS_CHARS; i++)
                        msg.push_back(8'($urandom));
                end
                2:
                begin
                    len = $urandom_range(12, 0);
                    msg.push_back(MEC_RT);
                    msg.push_back(8'($urandom));
                    msg.push_back(8'($urandom));
                    msg.push_back(8'(len));
                    for (int i = 0; i < len; i++)
                        msg.push_back(8'($urandom));
                end
                3:
                begin
                    msg.push_back(MEC_SHORT);
                    repeat (3) msg.push_back(8'($urandom));
                end
                default:
                begin
                    len = $urandom_range(3, 0);
                    msg.push_back(MEC_VAR);
                    msg.push_back(8'(len));
                    repeat (len) msg.push_back(8'($urandom));
                end
            endcase
        end
        if ($urandom_range(9, 0) == 0)
            msg.push_back(8'($urandom));
        push_frame(msg, $urandom_range(7, 0) == 0);
    endfunction

    function automatic void push_reads();
        repeat ($urandom_range(4, 1))
        begin
            if ($urandom_range(1, 0))
                pending_reqs.push_back(make_req(CMD_READ_PS, 8'($urandom),
                    8'($urandom_range(9, 0)), 8'($urandom)));
            else
                pending_reqs.push_back(make_req(CMD_READ_RT, 8'($urandom),
                    $urandom_range(3, 0) == 0 ? 8'($urandom) : 8'($urandom_range(12, 0)),
                    8'($urandom)));
        end
    endfunction

    // Drive a request at the falling edge; hold it until it is taken
    always @(negedge clk or negedge rst_n)
    begin
        if (!rst_n)
            req_valid <= 1'b0;
        else if (!req_valid || req_taken)
        begin
            if (pending_reqs.size() != 0 && !hold_sender
                && $urandom_range(99, 0) >= send_idle_pct)
            begin
                req_valid <= 1'b1;
                req <= pending_reqs.pop_front();
            end
            else
                req_valid <= 1'b0;
        end
    end

    always @(negedge clk or negedge rst_n)
    begin
        if (!rst_n)
            res_stall <= 1'b0;
        else
            res_stall <= ($urandom_range(99, 0) < recv_idle_pct);
    end

    // Predict on accepted requests, check accepted results
    always @(posedge clk)
    begin
        res_t exp_r;
        req_taken = rst_n && req_valid && !req_stall;
        if (rst_n)
        begin
            cycle_count++;
            if (req_valid && !req_stall)
                expected_res.push_back(decode_request(req));
            if (res_valid && !res_stall)
            begin
                if (expected_res.size() == 0)
                begin
                    $error("result with no request pending: %p", res);
                    error_count++;
                end
                else
                begin
                    exp_r = expected_res.pop_front();
                    if (res.read_char !== exp_r.read_char)
                    begin
                        $error("read_char exp %h got %h", exp_r.read_char, res.read_char);
                        error_count++;
                    end
                    if (res.frame_done !== exp_r.frame_done)
                    begin
                        $error("frame_done exp %b got %b", exp_r.frame_done, res.frame_done);
                        error_count++;
                    end
                    if (res.crc_good !== exp_r.crc_good)
                    begin
                        $error("crc_good exp %b got %b", exp_r.crc_good, res.crc_good);
                        error_count++;
                    end
                    if (res.ps_updated !== exp_r.ps_updated)
                    begin
                        $error("ps_updated exp %b got %b", exp_r.ps_updated, res.ps_updated);
                        error_count++;
                    end
                    if (res.rt_updated !== exp_r.rt_updated)
                    begin
                        $error("rt_updated exp %b got %b", exp_r.rt_updated, res.rt_updated);
                        error_count++;
                    end
                    if (res.frame_overflow !== exp_r.frame_overflow)
                    begin
                        $error("frame_overflow exp %b got %b", exp_r.frame_overflow,
                            res.frame_overflow);
                        error_count++;
                    end
                end
            end
            if (cycle_count > CYCLE_LIMIT)
            begin
                $display("RESULT: ERROR");
                $finish;
            end
        end
    end

    initial
    begin
        logic [7:0] msg[$];
        int phase_items;
        int before_size;
        rst_n = 1'b0;
        req_valid = 1'b0;
        req = '0;
        res_stall = 1'b0;
        hold_sender = 1'b0;
        req_taken = 1'b0;
        send_idle_pct = 24;
        recv_idle_pct = 63;
        error_count = 0;
        cycle_count = 0;
        frame_len = 0;
        collecting = 1'b0;
        esc_seen = 1'b0;
        channel_set = 1'b0;
        cur_channel = 8'h00;
        foreach (frame_buf[i])
            frame_buf[i] = 8'h00;
        foreach (ps_chars[i])
            ps_chars[i] = 8'h00;
        foreach (rt_chars[i])
            rt_chars[i] = 8'h00;
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed: channel, PS and RT frames, stuffing, escapes, short frame
        pending_reqs.push_back(make_req(CMD_CHANNEL, 8'h00, 8'h00, 8'h00));
        msg = {MEC_PS, 8'h00, 8'h00, 8'hFD, 8'hFE, 8'hFF, 8'h41, 8'h42, 8'h43, 8'h44, 8'h00};
        push_frame(msg, 1'b0);
        pending_reqs.push_back(make_req(CMD_READ_PS, 8'h00, 8'd0, 8'h00));
        pending_reqs.push_back(make_req(CMD_READ_PS, 8'h00, 8'd7, 8'h00));
        pending_reqs.push_back(make_req(CMD_READ_PS, 8'h00, 8'hFF, 8'h00));
        msg = {MEC_RT, 8'h00, 8'h00, 8'd3, 8'h00, 8'h58, 8'hFF};
        push_frame(msg, 1'b0);
        pending_reqs.push_back(make_req(CMD_READ_RT, 8'h00, 8'd1, 8'hFF));
        pending_reqs.push_back(make_req(CMD_READ_RT, 8'h00, 8'hFF, 8'hFF));
        msg = {MEC_RT, 8'h00, 8'h00, 8'd0, MEC_SHORT, 8'h1, 8'h2, 8'h3, 8'h77};
        push_frame(msg, 1'b0);
        push_frame(msg, 1'b1);
        // Escape then ordinary byte, escape then stop byte, short body
        push_byte(START_BYTE);
        push_byte(ESC_BYTE);
        push_byte(8'h03);
        push_byte(START_BYTE);
        push_byte(ESC_BYTE);
        push_byte(STOP_BYTE);
        pending_reqs.push_back(make_req(CMD_CHANNEL, 8'hFF, 8'hFF, 8'hFF));
        pending_reqs.push_back(make_req(CMD_CHANNEL, 8'hFF, 8'hFF, 8'hFF));
        // Overflow: more bytes than the frame store holds
        push_byte(START_BYTE);
        for (int i = 0; i < FB + 1; i++)
            push_byte(8'($urandom_range(250, 0)));
        push_byte(STOP_BYTE);

        // Random part in three idling phases
        for (int ph = 0; ph < 3; ph++)
        begin
            phase_items = 0;
            while (phase_items < 250)
            begin
                before_size = pending_reqs.size();
                case ($urandom_range(9, 0))
                    0: pending_reqs.push_back(make_req(CMD_CHANNEL, 8'($urandom),
                           8'($urandom), 8'($urandom_range(3, 0) == 0 ? $urandom : 1)));
                    1: push_byte(8'($urandom));
                    2, 3: push_reads();
                    default: push_random_frame();
                endcase
                phase_items += pending_reqs.size() - before_size;
                wait (pending_reqs.size() < 40);
            end
            repeat (4)
            begin
                push_random_frame();
                push_reads();
                wait (pending_reqs.size() < 40);
            end
            // Let everything drain before the next idling mix
            wait (pending_reqs.size() == 0);
            hold_sender = 1'b1;
            wait (!req_valid);
            wait (expected_res.size() == 0);
            @(negedge clk);
            hold_sender = 1'b0;
            if (ph == 0)
            begin
                send_idle_pct = 63;
                recv_idle_pct = 24;
            end
            else
            begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            repeat (4)
            begin
                push_random_frame();
                push_reads();
                if ($urandom_range(3, 0) == 0)
                    push_byte(8'($urandom));
                wait (pending_reqs.size() < 40);
            end
        end

        wait (pending_reqs.size() == 0);
        wait (!req_valid);
        wait (expected_res.size() == 0);
        repeat (2000) @(posedge clk);
        if (error_count == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end
endmodule
